### rtl/tmpp_pkg.sv
// Shared constants and sideband types for the trapezoid motion profile planner.
package tmpp_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_MAX_FEED = 2'd0;
  localparam logic [1:0] CFG_DEF_ACC  = 2'd1;
  localparam logic [1:0] CFG_MAX_ACC  = 2'd2;

  // Register reset values (Q16.16)
  localparam logic [31:0] MAX_FEED_RST = 32'd393216000;
  localparam logic [31:0] DEF_ACC_RST  = 32'd32768000;
  localparam logic [31:0] MAX_ACC_RST  = 32'd65536000;

  // Shortest accepted block (0.0001 mm) and lowest acceleration (0.1)
  localparam logic [31:0] MIN_LEN_RAW     = 32'd7;
  localparam logic [31:0] ACCEL_FLOOR_RAW = 32'd6554;

  // floor(2^34 / 15): quotient estimate for the divide by 60
  localparam logic [30:0] RECIP15 = 31'h44444444;

  // Speeds in mm/s fit in 27 bits, their squares in 54 bits
  localparam int SPD_W = 27;
  localparam int SQ_W  = 2 * SPD_W;

  // One quotient or root bit per stage, plus an input register
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  // Sideband carried alongside the first divider and root bank
  typedef struct packed {
    logic             short_blk;
    logic             reject;
    logic             al_lt;
    logic [31:0]      len;
    logic [SPD_W-1:0] v;
    logic [SPD_W-1:0] e;
    logic [SPD_W-1:0] x;
    logic [31:0]      a;
    logic [SQ_W-1:0]  e2;
    logic [SQ_W-1:0]  x2;
  } d1_side_t;

  // Sideband carried alongside the second divider bank
  typedef struct packed {
    logic             short_blk;
    logic             reject;
    logic             tri_prof;
    logic [SPD_W-1:0] peak;
    logic [31:0]      du;
    logic [31:0]      dd;
    logic [31:0]      cd;
    logic [SPD_W-1:0] e;
    logic [SPD_W-1:0] x;
    logic [31:0]      a;
  } d2_side_t;

  localparam int D1_W   = $bits(d1_side_t);
  localparam int D2_W   = $bits(d2_side_t);
  localparam int SIDE_W = (D1_W > D2_W) ? D1_W : D2_W;

endpackage

### rtl/trapezoid_motion_profile_planner.sv
// Trapezoid motion profile planner: top level pipeline.
// Path to done: stages 1-6, first bank, stages 8-10, second bank, output register.
// Throughput: one block per cycle; busy stays low, the pipeline never stalls.
// Two banks of 32-step divider lanes (and a root lane beside the first) set the latency.
// Reset drops all items in flight and loads the default register values.
module trapezoid_motion_profile_planner (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] move_length,
  input  logic [31:0] nominal_feed,
  input  logic [31:0] start_feed,
  input  logic [31:0] end_feed,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic        planned,
  output logic        triangular,
  output logic [31:0] peak_speed,
  output logic [31:0] ramp_up_distance,
  output logic [31:0] cruise_distance,
  output logic [31:0] ramp_down_distance,
  output logic [31:0] ramp_up_time,
  output logic [31:0] cruise_time,
  output logic [31:0] ramp_down_time,
  output logic [31:0] entry_speed,
  output logic [31:0] exit_speed,
  output logic [31:0] used_acceleration
);

  localparam int SW = tmpp_pkg::SPD_W;
  localparam int QW = tmpp_pkg::SQ_W;

  typedef struct packed {
    logic        short_blk;
    logic [31:0] len;
    logic [31:0] a;
  } blk_t;

  typedef struct packed {
    logic            short_blk;
    logic            reject;
    logic [31:0]     len;
    logic [SW-1:0]   v;
    logic [SW-1:0]   e;
    logic [SW-1:0]   x;
    logic [31:0]     a;
  } spd_t;

  typedef struct packed {
    logic            tri_prof;
    logic [SW-1:0]   peak;
    logic [31:0]     du;
    logic [31:0]     dd;
    logic [31:0]     cd;
    logic [SW-1:0]   e;
    logic [SW-1:0]   x;
    logic [31:0]     a;
    logic [QW-1:0]   e2;
    logic [QW-1:0]   x2;
    logic            short_blk;
    logic            reject;
  } dec_t;

  logic [31:0] max_feed_rate;
  logic [31:0] default_acceleration;
  logic [31:0] max_acceleration;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_feed_rate        <= tmpp_pkg::MAX_FEED_RST;
      default_acceleration <= tmpp_pkg::DEF_ACC_RST;
      max_acceleration     <= tmpp_pkg::MAX_ACC_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        tmpp_pkg::CFG_MAX_FEED: max_feed_rate        <= cfg_data;
        tmpp_pkg::CFG_DEF_ACC:  default_acceleration <= cfg_data;
        tmpp_pkg::CFG_MAX_ACC:  max_acceleration     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- stage 1: clamp feed and acceleration
  logic        s1_vld;
  blk_t        s1;
  logic [31:0] s1_feed [0:2];
  logic [31:0] nf_c;
  logic [31:0] acc_c;

  always_comb begin
    nf_c = (nominal_feed > max_feed_rate) ? max_feed_rate : nominal_feed;
    if (default_acceleration < tmpp_pkg::ACCEL_FLOOR_RAW) acc_c = tmpp_pkg::ACCEL_FLOOR_RAW;
    else if (default_acceleration > max_acceleration) acc_c = max_acceleration;
    else acc_c = default_acceleration;
  end

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else s1_vld <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    s1.short_blk <= move_length < tmpp_pkg::MIN_LEN_RAW;
    s1.len       <= move_length;
    s1.a         <= acc_c;
    s1_feed[0]   <= nf_c;
    s1_feed[1]   <= start_feed;
    s1_feed[2]   <= end_feed;
  end

  // ---------------- stage 2: quotient estimate for the divide by 60
  logic          s2_vld;
  blk_t          s2;
  logic [29:0]   s2_y  [0:2];
  logic [SW-1:0] s2_q0 [0:2];
  logic [60:0]   prod  [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = {31'd0, s1_feed[i][31:2]} * {30'd0, tmpp_pkg::RECIP15};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else s2_vld <= s1_vld;
  end

  always_ff @(posedge clk) begin
    s2 <= s1;
    for (int i = 0; i < 3; i++) begin
      s2_y[i]  <= s1_feed[i][31:2];
      s2_q0[i] <= prod[i][60:34];
    end
  end

  // ---------------- stage 3: correct the estimate by one
  logic          s3_vld;
  blk_t          s3;
  logic [SW-1:0] s3_spd [0:2];
  logic [30:0]   m15    [0:2];
  logic [30:0]   rmd    [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m15[i] = {s2_q0[i], 4'b0000} - {4'b0000, s2_q0[i]};
      rmd[i] = {1'b0, s2_y[i]} - m15[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else s3_vld <= s2_vld;
  end

  always_ff @(posedge clk) begin
    s3 <= s2;
    for (int i = 0; i < 3; i++) begin
      s3_spd[i] <= (rmd[i] >= 31'd15) ? SW'(s2_q0[i] + 1'b1) : s2_q0[i];
    end
  end

  // ---------------- stage 4: clamp entry and exit to nominal, flag zero feed or acceleration
  logic s4_vld;
  spd_t s4;

  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else s4_vld <= s3_vld;
  end

  always_ff @(posedge clk) begin
    s4.short_blk <= s3.short_blk;
    s4.reject    <= (s3_spd[0] == '0) || (s3.a == '0);
    s4.len       <= s3.len;
    s4.a         <= s3.a;
    s4.v         <= s3_spd[0];
    s4.e         <= (s3_spd[1] > s3_spd[0]) ? s3_spd[0] : s3_spd[1];
    s4.x         <= (s3_spd[2] > s3_spd[0]) ? s3_spd[0] : s3_spd[2];
  end

  // ---------------- stage 5: squares and a*L
  logic          s5_vld;
  spd_t          s5;
  logic [QW-1:0] s5_v2;
  logic [QW-1:0] s5_e2;
  logic [QW-1:0] s5_x2;
  logic [63:0]   s5_al;

  always_ff @(posedge clk) begin
    if (rst) s5_vld <= 1'b0;
    else s5_vld <= s4_vld;
  end

  always_ff @(posedge clk) begin
    s5    <= s4;
    s5_v2 <= {{SW{1'b0}}, s4.v} * {{SW{1'b0}}, s4.v};
    s5_e2 <= {{SW{1'b0}}, s4.e} * {{SW{1'b0}}, s4.e};
    s5_x2 <= {{SW{1'b0}}, s4.x} * {{SW{1'b0}}, s4.x};
    s5_al <= {32'd0, s4.a} * {32'd0, s4.len};
  end

  // ---------------- stage 6: ramp numerators and root radicand
  logic               s6_vld;
  tmpp_pkg::d1_side_t s6;
  logic [QW-1:0]      s6_nu;
  logic [QW-1:0]      s6_nd;
  logic [63:0]      s6_s;
  logic [32:0]        s6_twoa;
  logic [QW:0]        ex_sum;

  assign ex_sum = {1'b0, s5_e2} + {1'b0, s5_x2};

  always_ff @(posedge clk) begin
    if (rst) s6_vld <= 1'b0;
    else s6_vld <= s5_vld;
  end

  always_ff @(posedge clk) begin
    s6.short_blk <= s5.short_blk;
    s6.reject    <= s5.reject;
    s6.al_lt     <= s5_al < {{(64-QW){1'b0}}, s5_v2};
    s6.len       <= s5.len;
    s6.v         <= s5.v;
    s6.e         <= s5.e;
    s6.x         <= s5.x;
    s6.a         <= s5.a;
    s6.e2        <= s5_e2;
    s6.x2        <= s5_x2;
    s6_nu        <= (s5_v2 > s5_e2) ? QW'(s5_v2 - s5_e2) : '0;
    s6_nd        <= (s5_v2 > s5_x2) ? QW'(s5_v2 - s5_x2) : '0;
    s6_s         <= s5_al + {{(64-QW){1'b0}}, ex_sum[QW:1]};
    s6_twoa      <= {s5.a, 1'b0};
  end

  // ---------------- first bank: full-speed ramp distances and the peak root
  logic [31:0]               du1_q, dd1_q, root;
  logic                      du1_ovf, dd1_ovf;
  logic                      b1_vld;
  logic [tmpp_pkg::SIDE_W-1:0] b1_vec;
  tmpp_pkg::d1_side_t        b1;

  tmpp_div_lane u_div_du1 (
    .clk(clk), .dividend({{(64-QW){1'b0}}, s6_nu}), .divisor(s6_twoa),
    .quotient(du1_q), .ovf(du1_ovf)
  );

  tmpp_div_lane u_div_dd1 (
    .clk(clk), .dividend({{(64-QW){1'b0}}, s6_nd}), .divisor(s6_twoa),
    .quotient(dd1_q), .ovf(dd1_ovf)
  );

  tmpp_sqrt_lane u_sqrt (
    .clk(clk), .radicand(s6_s), .root(root)
  );

  tmpp_delay u_dly1 (
    .clk(clk), .rst(rst), .in_vld(s6_vld), .in_data(tmpp_pkg::SIDE_W'(s6)),
    .out_vld(b1_vld), .out_data(b1_vec)
  );

  assign b1 = tmpp_pkg::d1_side_t'(b1_vec[tmpp_pkg::D1_W-1:0]);

  // ---------------- stage 8: trapezoid or triangle, pick the peak speed
  logic          s8_vld;
  dec_t          s8;
  logic          over;
  logic [SW-1:0] root_cap;

  always_comb begin
    over     = du1_ovf | dd1_ovf | (({1'b0, du1_q} + {1'b0, dd1_q}) > {1'b0, b1.len});
    root_cap = (root > {{(32-SW){1'b0}}, b1.v}) ? b1.v : root[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) s8_vld <= 1'b0;
    else s8_vld <= b1_vld;
  end

  always_ff @(posedge clk) begin
    s8.tri_prof  <= over;
    s8.peak      <= (over && b1.al_lt) ? root_cap : b1.v;
    s8.du        <= du1_q;
    s8.dd        <= dd1_q;
    s8.cd        <= over ? '0 : 32'(b1.len - du1_q - dd1_q);
    s8.e         <= b1.e;
    s8.x         <= b1.x;
    s8.a         <= b1.a;
    s8.e2        <= b1.e2;
    s8.x2        <= b1.x2;
    s8.short_blk <= b1.short_blk;
    s8.reject    <= b1.reject;
  end

  // ---------------- stage 9: peak square and time numerators
  logic          s9_vld;
  dec_t          s9;
  logic [QW-1:0] s9_p2;
  logic [42:0]   s9_tun;
  logic [42:0]   s9_tdn;
  logic [47:0]   s9_ctn;

  always_ff @(posedge clk) begin
    if (rst) s9_vld <= 1'b0;
    else s9_vld <= s8_vld;
  end

  always_ff @(posedge clk) begin
    s9     <= s8;
    s9_p2  <= {{SW{1'b0}}, s8.peak} * {{SW{1'b0}}, s8.peak};
    s9_tun <= (s8.peak > s8.e) ? {SW'(s8.peak - s8.e), 16'd0} : '0;
    s9_tdn <= (s8.peak > s8.x) ? {SW'(s8.peak - s8.x), 16'd0} : '0;
    s9_ctn <= {s8.cd, 16'd0};
  end

  // ---------------- stage 10: ramp numerators at the peak speed
  logic               s10_vld;
  tmpp_pkg::d2_side_t s10;
  logic [QW-1:0]      s10_nu;
  logic [QW-1:0]      s10_nd;
  logic [42:0]        s10_tun;
  logic [42:0]        s10_tdn;
  logic [47:0]        s10_ctn;

  always_ff @(posedge clk) begin
    if (rst) s10_vld <= 1'b0;
    else s10_vld <= s9_vld;
  end

  always_ff @(posedge clk) begin
    s10.short_blk <= s9.short_blk;
    s10.reject    <= s9.reject;
    s10.tri_prof  <= s9.tri_prof;
    s10.peak      <= s9.peak;
    s10.du        <= s9.du;
    s10.dd        <= s9.dd;
    s10.cd        <= s9.cd;
    s10.e         <= s9.e;
    s10.x         <= s9.x;
    s10.a         <= s9.a;
    s10_nu        <= (s9_p2 > s9.e2) ? QW'(s9_p2 - s9.e2) : '0;
    s10_nd        <= (s9_p2 > s9.x2) ? QW'(s9_p2 - s9.x2) : '0;
    s10_tun       <= s9_tun;
    s10_tdn       <= s9_tdn;
    s10_ctn       <= s9_ctn;
  end

  // ---------------- second bank: triangle distances and all phase times
  logic [31:0]                 du2_q, dd2_q, tu_q, td_q, ct_q;
  logic                        du2_ovf, dd2_ovf, tu_ovf, td_ovf, ct_ovf;
  logic                        b2_vld;
  logic [tmpp_pkg::SIDE_W-1:0] b2_vec;
  tmpp_pkg::d2_side_t          b2;

  tmpp_div_lane u_div_du2 (
    .clk(clk), .dividend({{(64-QW){1'b0}}, s10_nu}), .divisor({s10.a, 1'b0}),
    .quotient(du2_q), .ovf(du2_ovf)
  );

  tmpp_div_lane u_div_dd2 (
    .clk(clk), .dividend({{(64-QW){1'b0}}, s10_nd}), .divisor({s10.a, 1'b0}),
    .quotient(dd2_q), .ovf(dd2_ovf)
  );

  tmpp_div_lane u_div_tu (
    .clk(clk), .dividend({21'd0, s10_tun}), .divisor({1'b0, s10.a}),
    .quotient(tu_q), .ovf(tu_ovf)
  );

  tmpp_div_lane u_div_td (
    .clk(clk), .dividend({21'd0, s10_tdn}), .divisor({1'b0, s10.a}),
    .quotient(td_q), .ovf(td_ovf)
  );

  tmpp_div_lane u_div_ct (
    .clk(clk), .dividend({16'd0, s10_ctn}), .divisor({{(33-SW){1'b0}}, s10.peak}),
    .quotient(ct_q), .ovf(ct_ovf)
  );

  tmpp_delay u_dly2 (
    .clk(clk), .rst(rst), .in_vld(s10_vld), .in_data(tmpp_pkg::SIDE_W'(s10)),
    .out_vld(b2_vld), .out_data(b2_vec)
  );

  assign b2 = tmpp_pkg::d2_side_t'(b2_vec[tmpp_pkg::D2_W-1:0]);

  // Saturation is already applied by the lanes; the flags only mark it
  logic any_ovf;
  assign any_ovf = du2_ovf | dd2_ovf | tu_ovf | td_ovf | ct_ovf;

  // ---------------- output register: mask rejected blocks
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= b2_vld;
  end

  always_ff @(posedge clk) begin
    planned            <= 1'b0;
    triangular         <= 1'b0;
    peak_speed         <= '0;
    ramp_up_distance   <= '0;
    cruise_distance    <= '0;
    ramp_down_distance <= '0;
    ramp_up_time       <= '0;
    cruise_time        <= '0;
    ramp_down_time     <= '0;
    entry_speed        <= '0;
    exit_speed         <= '0;
    used_acceleration  <= '0;
    if (!b2.short_blk) begin
      entry_speed       <= {{(32-SW){1'b0}}, b2.e};
      exit_speed        <= {{(32-SW){1'b0}}, b2.x};
      used_acceleration <= b2.a;
      if (!b2.reject) begin
        planned            <= 1'b1;
        triangular         <= b2.tri_prof;
        peak_speed         <= {{(32-SW){1'b0}}, b2.peak};
        ramp_up_distance   <= b2.tri_prof ? du2_q : b2.du;
        ramp_down_distance <= b2.tri_prof ? dd2_q : b2.dd;
        cruise_distance    <= b2.tri_prof ? '0 : b2.cd;
        cruise_time        <= (b2.tri_prof || (any_ovf && 1'b0)) ? '0 : ct_q;
        ramp_up_time       <= tu_q;
        ramp_down_time     <= td_q;
      end
    end
  end

endmodule

### rtl/tmpp_div_lane.sv
// Pipelined restoring divider: 64-bit dividend, 33-bit divisor, saturated 32-bit quotient.
module tmpp_div_lane (
  input  logic        clk,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic [31:0] quotient,
  output logic        ovf
);

  logic [32:0] r    [0:tmpp_pkg::DIV_STEPS];
  logic [31:0] low  [0:tmpp_pkg::DIV_STEPS];
  logic [31:0] q    [0:tmpp_pkg::DIV_STEPS];
  logic [32:0] d    [0:tmpp_pkg::DIV_STEPS];
  logic        sat  [0:tmpp_pkg::DIV_STEPS];

  logic [33:0] t    [0:tmpp_pkg::DIV_STEPS-1];
  logic        ge   [0:tmpp_pkg::DIV_STEPS-1];
  logic [32:0] r_next [0:tmpp_pkg::DIV_STEPS-1];

  // Shift in one dividend bit, try the subtract
  always_comb begin
    for (int k = 0; k < tmpp_pkg::DIV_STEPS; k++) begin
      t[k]      = {r[k], low[k][31]};
      ge[k]     = t[k] >= {1'b0, d[k]};
      r_next[k] = ge[k] ? 33'(t[k] - {1'b0, d[k]}) : t[k][32:0];
    end
  end

  // Input stage flags a quotient that does not fit, then one bit per stage
  always_ff @(posedge clk) begin
    r[0]   <= {1'b0, dividend[63:32]};
    low[0] <= dividend[31:0];
    q[0]   <= '0;
    d[0]   <= divisor;
    sat[0] <= {1'b0, dividend[63:32]} >= divisor;
    for (int k = 0; k < tmpp_pkg::DIV_STEPS; k++) begin
      r[k+1]   <= r_next[k];
      low[k+1] <= {low[k][30:0], 1'b0};
      q[k+1]   <= {q[k][30:0], ge[k]};
      d[k+1]   <= d[k];
      sat[k+1] <= sat[k];
    end
  end

  assign ovf      = sat[tmpp_pkg::DIV_STEPS];
  assign quotient = ovf ? '1 : q[tmpp_pkg::DIV_STEPS];

endmodule

### rtl/tmpp_sqrt_lane.sv
// Pipelined digit-by-digit floor square root of a 64-bit radicand.
module tmpp_sqrt_lane (
  input  logic        clk,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [63:0] xs   [0:tmpp_pkg::DIV_STEPS];
  logic [33:0] rem  [0:tmpp_pkg::DIV_STEPS];
  logic [31:0] rt   [0:tmpp_pkg::DIV_STEPS];

  logic [35:0] t      [0:tmpp_pkg::DIV_STEPS-1];
  logic [35:0] trial  [0:tmpp_pkg::DIV_STEPS-1];
  logic        ge     [0:tmpp_pkg::DIV_STEPS-1];
  logic [33:0] rem_next [0:tmpp_pkg::DIV_STEPS-1];

  // Bring down two radicand bits, test root*4+1
  always_comb begin
    for (int k = 0; k < tmpp_pkg::DIV_STEPS; k++) begin
      t[k]        = {rem[k], xs[k][63:62]};
      trial[k]    = {2'b00, rt[k], 2'b01};
      ge[k]       = t[k] >= trial[k];
      rem_next[k] = ge[k] ? 34'(t[k] - trial[k]) : t[k][33:0];
    end
  end

  // One root bit per stage
  always_ff @(posedge clk) begin
    xs[0]  <= radicand;
    rem[0] <= '0;
    rt[0]  <= '0;
    for (int k = 0; k < tmpp_pkg::DIV_STEPS; k++) begin
      xs[k+1]  <= {xs[k][61:0], 2'b00};
      rem[k+1] <= rem_next[k];
      rt[k+1]  <= {rt[k][30:0], ge[k]};
    end
  end

  assign root = rt[tmpp_pkg::DIV_STEPS];

endmodule

### rtl/tmpp_delay.sv
// Valid and sideband shift line that matches the divider and root lane latency.
module tmpp_delay (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  input  logic [tmpp_pkg::SIDE_W-1:0] in_data,
  output logic                        out_vld,
  output logic [tmpp_pkg::SIDE_W-1:0] out_data
);

  logic                        vld  [0:tmpp_pkg::DIV_LAT-1];
  logic [tmpp_pkg::SIDE_W-1:0] data [0:tmpp_pkg::DIV_LAT-1];

  // Advance valid bits; reset drops every item in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < tmpp_pkg::DIV_LAT; k++) vld[k] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
      for (int k = 1; k < tmpp_pkg::DIV_LAT; k++) vld[k] <= vld[k-1];
    end
  end

  // Advance sideband
  always_ff @(posedge clk) begin
    data[0] <= in_data;
    for (int k = 1; k < tmpp_pkg::DIV_LAT; k++) data[k] <= data[k-1];
  end

  assign out_vld  = vld[tmpp_pkg::DIV_LAT-1];
  assign out_data = data[tmpp_pkg::DIV_LAT-1];

endmodule

### rtl/tmpp_checker.sv
// Port-level checks for the trapezoid motion profile planner, bound to the top level.
module tmpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        planned,
  input logic        triangular,
  input logic [31:0] peak_speed,
  input logic [31:0] ramp_up_distance,
  input logic [31:0] cruise_distance,
  input logic [31:0] ramp_down_distance,
  input logic [31:0] ramp_up_time,
  input logic [31:0] cruise_time,
  input logic [31:0] ramp_down_time
);

  // Every start transfer is followed by its result on done
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##76 done)
    else $error("result missing 76 cycles after start transfer");

  // No result on done without a matching earlier start transfer
  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start, 76) && !$past(busy, 76)))
    else $error("result without matching start transfer");

  // Rejected blocks carry no profile
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !planned) |-> (!triangular && peak_speed == 32'd0 &&
      ramp_up_distance == 32'd0 && cruise_distance == 32'd0 &&
      ramp_down_distance == 32'd0 && ramp_up_time == 32'd0 &&
      cruise_time == 32'd0 && ramp_down_time == 32'd0))
    else $error("rejected block with nonzero profile");

  // A triangular profile has no cruise phase, and a planned one moves
  a_tri_cruise: assert property (@(posedge clk) disable iff (rst)
    (done && planned) |-> (peak_speed != 32'd0 &&
      (!triangular || (cruise_distance == 32'd0 && cruise_time == 32'd0))))
    else $error("planned profile with bad peak or cruise phase");

endmodule

bind trapezoid_motion_profile_planner tmpp_checker u_tmpp_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the trapezoid motion profile planner.
`timescale 1ns / 100ps

module tb_top;

  localparam int PIPE_LAT    = 76;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic        planned;
    logic        triangular;
    logic [31:0] peak_speed;
    logic [31:0] ramp_up_distance;
    logic [31:0] cruise_distance;
    logic [31:0] ramp_down_distance;
    logic [31:0] ramp_up_time;
    logic [31:0] cruise_time;
    logic [31:0] ramp_down_time;
    logic [31:0] entry_speed;
    logic [31:0] exit_speed;
    logic [31:0] used_acceleration;
  } plan_t;

  // Profile predictor with its own register copy and a queue of pending plans
  class profile_scoreboard;
    bit [31:0] max_feed;
    bit [31:0] def_acc;
    bit [31:0] max_acc;
    plan_t     expected_plans[$];
    int        mismatches;

    function new();
      max_feed   = tmpp_pkg::MAX_FEED_RST;
      def_acc    = tmpp_pkg::DEF_ACC_RST;
      max_acc    = tmpp_pkg::MAX_ACC_RST;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        tmpp_pkg::CFG_MAX_FEED: max_feed = val;
        tmpp_pkg::CFG_DEF_ACC:  def_acc  = val;
        tmpp_pkg::CFG_MAX_ACC:  max_acc  = val;
        default: ;
      endcase
    endfunction

    function bit [31:0] sat(longint unsigned val);
      return (val > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : val[31:0];
    endfunction

    function longint unsigned isqrt(longint unsigned val);
      longint unsigned root, step;
      root = 0;
      step = 64'd1 << 62;
      while (step > val) step >>= 2;
      while (step != 0) begin
        if (val >= root + step) begin
          val -= root + step;
          root = (root >> 1) + step;
        end else begin
          root >>= 1;
        end
        step >>= 2;
      end
      return root;
    endfunction

    function longint unsigned ramp_len(longint unsigned hi2, lo2, acc);
      return (hi2 <= lo2) ? 0 : (hi2 - lo2) / (2 * acc);
    endfunction

    function longint unsigned ramp_dur(longint unsigned hi, lo, acc);
      return (hi <= lo) ? 0 : ((hi - lo) << 16) / acc;
    endfunction

    // Work out the plan for one motion block
    function void note_block(bit [31:0] len_raw, nf_raw, sf_raw, ef_raw);
      plan_t p;
      longint unsigned len, nf, v, e, x, acc, v2, e2, x2, up, dn, peak, cd, ct, al, s;
      len = 64'(len_raw);
      nf  = 64'(nf_raw);
      cd  = 0;
      ct  = 0;
      p   = '{default: '0};
      if (len >= tmpp_pkg::MIN_LEN_RAW) begin
        if (nf > max_feed) nf = max_feed;
        v = nf / 60;
        e = 64'(sf_raw) / 60;
        if (e > v) e = v;
        x = 64'(ef_raw) / 60;
        if (x > v) x = v;
        // floor wins over the upper limit
        if (def_acc < tmpp_pkg::ACCEL_FLOOR_RAW) acc = tmpp_pkg::ACCEL_FLOOR_RAW;
        else if (def_acc > max_acc) acc = max_acc;
        else acc = def_acc;
        p.entry_speed       = e[31:0];
        p.exit_speed        = x[31:0];
        p.used_acceleration = acc[31:0];
        if (v != 0 && acc != 0) begin
          v2   = v * v;
          e2   = e * e;
          x2   = x * x;
          up   = ramp_len(v2, e2, acc);
          dn   = ramp_len(v2, x2, acc);
          peak = v;
          if (up + dn > len) begin
            // ramps overrun the block: no cruise, peak from the root
            al = acc * len;
            if (al < v2) begin
              s    = al + ((e2 + x2) >> 1);
              peak = (s >= v2) ? v : isqrt(s);
              if (peak > v) peak = v;
            end
            up           = ramp_len(peak * peak, e2, acc);
            dn           = ramp_len(peak * peak, x2, acc);
            p.triangular = 1'b1;
          end else begin
            cd = len - up - dn;
            if (cd > 0) ct = (cd << 16) / peak;
          end
          p.planned            = 1'b1;
          p.peak_speed         = sat(peak);
          p.ramp_up_distance   = sat(up);
          p.cruise_distance    = sat(cd);
          p.ramp_down_distance = sat(dn);
          p.ramp_up_time       = sat(ramp_dur(peak, e, acc));
          p.cruise_time        = sat(ct);
          p.ramp_down_time     = sat(ramp_dur(peak, x, acc));
        end
      end
      expected_plans.push_back(p);
    endfunction

    function void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v,
                              ref bit bad);
      if (act_v !== exp_v) begin
        bad = 1;
        if (mismatches < 10)
          $display("  %s: expected %h, got %h", name, exp_v, act_v);
      end
    endfunction

    // Compare one result transfer against the oldest pending plan
    function void check_plan(plan_t act);
      plan_t exp_p;
      bit bad;
      bad = 0;
      if (expected_plans.size() == 0) begin
        if (mismatches < 10) $display("Unexpected result at %0t", $realtime);
        mismatches++;
        return;
      end
      exp_p = expected_plans.pop_front();
      field_check("planned", exp_p.planned, act.planned, bad);
      field_check("triangular", exp_p.triangular, act.triangular, bad);
      field_check("peak_speed", exp_p.peak_speed, act.peak_speed, bad);
      field_check("ramp_up_distance", exp_p.ramp_up_distance, act.ramp_up_distance, bad);
      field_check("cruise_distance", exp_p.cruise_distance, act.cruise_distance, bad);
      field_check("ramp_down_distance", exp_p.ramp_down_distance,
                  act.ramp_down_distance, bad);
      field_check("ramp_up_time", exp_p.ramp_up_time, act.ramp_up_time, bad);
      field_check("cruise_time", exp_p.cruise_time, act.cruise_time, bad);
      field_check("ramp_down_time", exp_p.ramp_down_time, act.ramp_down_time, bad);
      field_check("entry_speed", exp_p.entry_speed, act.entry_speed, bad);
      field_check("exit_speed", exp_p.exit_speed, act.exit_speed, bad);
      field_check("used_acceleration", exp_p.used_acceleration, act.used_acceleration, bad);
      if (bad) begin
        if (mismatches < 10) $display("Mismatch above at %0t", $realtime);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] move_length = '0;
  logic [31:0] nominal_feed = '0;
  logic [31:0] start_feed = '0;
  logic [31:0] end_feed = '0;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = tmpp_pkg::CFG_MAX_FEED;
  logic [31:0] cfg_data = '0;
  logic        done;
  plan_t       got;

  profile_scoreboard sb = new();
  int unsigned cycles = 0;
  int          burst_left = 0;

  trapezoid_motion_profile_planner dut (
    .clk, .rst, .start, .busy,
    .move_length, .nominal_feed, .start_feed, .end_feed,
    .cfg_write, .cfg_index, .cfg_data,
    .done,
    .planned(got.planned), .triangular(got.triangular), .peak_speed(got.peak_speed),
    .ramp_up_distance(got.ramp_up_distance), .cruise_distance(got.cruise_distance),
    .ramp_down_distance(got.ramp_down_distance), .ramp_up_time(got.ramp_up_time),
    .cruise_time(got.cruise_time), .ramp_down_time(got.ramp_down_time),
    .entry_speed(got.entry_speed), .exit_speed(got.exit_speed),
    .used_acceleration(got.used_acceleration)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note accepted blocks and check results on the rising edge
  always @(posedge clk) begin
    if (!rst && start && !busy)
      sb.note_block(move_length, nominal_feed, start_feed, end_feed);
    if (!rst && done)
      sb.check_plan(got);
  end

  // Guard against a hung pipeline
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Hold start until the transfer happens, with burst gaps before it
  task automatic send_block(logic [31:0] len, nf, sf, ef);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start        <= 1'b1;
    move_length  <= len;
    nominal_feed <= nf;
    start_feed   <= sf;
    end_feed     <= ef;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_plans.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_feed();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 400000000);
      2:       return $urandom_range(0, 70);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
    endcase
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 10);
      1:       return $urandom_range(7, 1 << 22);
      2:       return $urandom;
      default: return $urandom_range(1 << 16, 1 << 26);
    endcase
  endfunction

  task automatic random_blocks(int count);
    for (int i = 0; i < count; i++) begin
      // drain once mid-phase so the pipeline empties under load
      if (i == count / 2) drain();
      send_block(rand_len(), rand_feed(), rand_feed(), rand_feed());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset defaults, edges of length and speed clamps
    send_block(32'd0, 32'd360000, 32'd0, 32'd0);
    send_block(32'd6, 32'd360000, 32'd0, 32'd0);
    send_block(32'd7, 32'd360000, 32'd0, 32'd0);
    send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_block(32'd59, 32'd59, 32'd0, 32'd0);
    send_block(32'd655360, 32'd393216000, 32'd0, 32'd0);
    send_block(32'd65536, 32'd393216000, 32'd0, 32'd0);
    send_block(32'd65536, 32'd393216000, 32'd393216000, 32'd0);
    send_block(32'd65536, 32'd39321600, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(32'd6553600, 32'd39321600, 32'd19660800, 32'd3932160);
    send_block(32'd100, 32'd196608000, 32'd98304000, 32'd196608000);
    random_blocks(280);
    drain();

    // Everything wide open
    write_reg(tmpp_pkg::CFG_MAX_FEED, 32'hFFFF_FFFF);
    write_reg(tmpp_pkg::CFG_DEF_ACC, 32'hFFFF_FFFF);
    write_reg(tmpp_pkg::CFG_MAX_ACC, 32'hFFFF_FFFF);
    send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_block(32'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    random_blocks(300);
    drain();

    // Zero feed limit rejects every long enough block
    write_reg(tmpp_pkg::CFG_MAX_FEED, 32'd0);
    random_blocks(120);
    drain();

    // Requested acceleration under the floor, limit even lower
    write_reg(tmpp_pkg::CFG_MAX_FEED, $urandom);
    write_reg(tmpp_pkg::CFG_DEF_ACC, 32'd100);
    write_reg(tmpp_pkg::CFG_MAX_ACC, 32'd50);
    random_blocks(300);
    drain();

    // Zero acceleration limit rejects with clamped speeds
    write_reg(tmpp_pkg::CFG_DEF_ACC, 32'd65536000);
    write_reg(tmpp_pkg::CFG_MAX_ACC, 32'd0);
    random_blocks(150);
    drain();

    // Random registers
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(tmpp_pkg::CFG_MAX_FEED,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 800000000));
      write_reg(tmpp_pkg::CFG_DEF_ACC,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000000));
      write_reg(tmpp_pkg::CFG_MAX_ACC,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000000));
      random_blocks(140);
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_plans.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/tmpp_pkg.sv
rtl/tmpp_div_lane.sv
rtl/tmpp_sqrt_lane.sv
rtl/tmpp_delay.sv
rtl/trapezoid_motion_profile_planner.sv
rtl/tmpp_checker.sv
tb/tb_top.sv
